FILE: hw/rtl/rrjs_pkg.sv
// Shared types, widths and helpers for the response-ratio job scheduler.
`default_nettype none

package rrjs_pkg;

   localparam int BURST_W   = 16;
   localparam int ARRIVAL_W = 16;
   localparam int TIME_W    = 21;
   localparam int JOB_IDX_W = 4;
   localparam int JOB_W     = BURST_W + ARRIVAL_W;
   localparam int PROD_W    = TIME_W + BURST_W;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // control from the sequencer to the pick unit
   typedef struct packed {
      logic clear;       // drop best and earliest-arrival tracking
      logic cand_valid;  // job RAM read data is valid this cycle
      logic cand_done;   // done flag of the job being read
   } pick_ctl_type;

   // status back from the pick unit
   typedef struct packed {
      logic busy;        // candidates still in the compare pipeline
      logic best_valid;  // at least one arrived, unfinished job seen
   } pick_stat_type;

   // time plus burst, saturating at the top of the time range
   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0]  a,
                                                 input logic [BURST_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + (TIME_W+1)'(b);
      return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rrjs_job_ram.sv
// Job store: burst and arrival per slot, one write port, one registered read port.
`default_nettype none

module rrjs_job_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [ADDR_W-1:0]         wr_addr,
   input  wire logic [rrjs_pkg::JOB_W-1:0] wr_data,
   input  wire logic                      rd_en,
   input  wire logic [ADDR_W-1:0]         rd_addr,
   output logic      [rrjs_pkg::JOB_W-1:0] rd_data
);
   import rrjs_pkg::*;

   logic [JOB_W-1:0] mem [DEPTH];
   logic [JOB_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/rrjs_pick_unit.sv
// Pick unit: exact wait/burst ratio compare over a job scan, plus earliest pending arrival.
`default_nettype none

module rrjs_pick_unit #(
   parameter int IDX_W = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rrjs_pkg::pick_ctl_type        ctl,
   input  wire logic [IDX_W-1:0]              cand_idx,
   input  wire logic [rrjs_pkg::BURST_W-1:0]  cand_burst,
   input  wire logic [rrjs_pkg::ARRIVAL_W-1:0] cand_arrival,
   input  wire logic [rrjs_pkg::TIME_W-1:0]   cur_time,
   output rrjs_pkg::pick_stat_type            stat,
   output logic      [IDX_W-1:0]              best_idx,
   output logic      [rrjs_pkg::TIME_W-1:0]   best_wait,
   output logic      [rrjs_pkg::BURST_W-1:0]  best_burst,
   output logic      [rrjs_pkg::ARRIVAL_W-1:0] min_arrival
);
   import rrjs_pkg::*;

   logic                 s1_valid_ff;
   logic [TIME_W-1:0]    s1_wait_ff;
   logic [BURST_W-1:0]   s1_burst_ff;
   logic [IDX_W-1:0]     s1_idx_ff;
   logic                 s2_valid_ff;
   logic [TIME_W-1:0]    s2_wait_ff;
   logic [BURST_W-1:0]   s2_burst_ff;
   logic [IDX_W-1:0]     s2_idx_ff;
   logic [PROD_W-1:0]    lhs_ff;
   logic [PROD_W-1:0]    rhs_ff;
   logic                 best_valid_ff;
   logic [IDX_W-1:0]     best_idx_ff;
   logic [TIME_W-1:0]    best_wait_ff;
   logic [BURST_W-1:0]   best_burst_ff;
   logic [ARRIVAL_W-1:0] min_arr_ff;

   logic              arrived;
   logic              eligible;
   logic              take;
   logic [TIME_W-1:0] arr_ext;

   assign arr_ext  = TIME_W'(cand_arrival);
   assign arrived  = arr_ext <= cur_time;
   assign eligible = ctl.cand_valid && !ctl.cand_done && arrived;

   // greater ratio wins; equal ratio goes to the shorter burst; lower index kept otherwise
   assign take = !best_valid_ff || (lhs_ff > rhs_ff) ||
                 ((lhs_ff == rhs_ff) && (s2_burst_ff < best_burst_ff));

   // control
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
         min_arr_ff    <= {ARRIVAL_W{1'b1}};
      end else begin
         s1_valid_ff <= eligible;
         s2_valid_ff <= s1_valid_ff;
         if (s2_valid_ff) begin
            best_valid_ff <= 1'b1;
         end
         if (ctl.cand_valid && !ctl.cand_done && (cand_arrival < min_arr_ff)) begin
            min_arr_ff <= cand_arrival;
         end
      end
   end

   // payload; candidates never come in back-to-back cycles, so stage 2 sees the settled best
   always_ff @(posedge clock) begin
      s1_wait_ff  <= cur_time - arr_ext;
      s1_burst_ff <= cand_burst;
      s1_idx_ff   <= cand_idx;
      s2_wait_ff  <= s1_wait_ff;
      s2_burst_ff <= s1_burst_ff;
      s2_idx_ff   <= s1_idx_ff;
      lhs_ff      <= PROD_W'(s1_wait_ff) * PROD_W'(best_burst_ff);
      rhs_ff      <= PROD_W'(best_wait_ff) * PROD_W'(s1_burst_ff);
      if (s2_valid_ff && take) begin
         best_idx_ff   <= s2_idx_ff;
         best_wait_ff  <= s2_wait_ff;
         best_burst_ff <= s2_burst_ff;
      end
   end

   assign stat.busy       = s1_valid_ff || s2_valid_ff;
   assign stat.best_valid = best_valid_ff;
   assign best_idx        = best_idx_ff;
   assign best_wait       = best_wait_ff;
   assign best_burst      = best_burst_ff;
   assign min_arrival     = min_arr_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/response_ratio_job_scheduler_core.sv
// Top level of the highest-response-ratio-next job scheduler.
//
//   channel | direction | handshake           | carries
//   req_    | in        | req_valid/req_stall | burst, arrival, final mark of one job
//   rsp_    | out       | rsp_valid/rsp_stall | index, wait, turnaround, end mark
//
// Loading takes one cycle per item. An item with the final mark starts a schedule:
// each pick is a scan of the job RAM, jobs issued one at a time with a gap between them
// through the read port and the ratio multipliers, then the emit state hands the item to
// the output register. The first scan of a set, and any scan that finds no arrived
// job, only moves the clock to the earliest pending arrival and adds a scan.
// Reset is synchronous and clears control state; the job RAM holds no reset value.
// The output register parts the sides: a stalled result holds there while the next
// scan runs, and the block stops only when a second result is ready.
`default_nettype none

module response_ratio_job_scheduler_core #(
   parameter int MAX_JOBS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [rrjs_pkg::BURST_W-1:0]    req_burst_time,
   input  wire logic [rrjs_pkg::ARRIVAL_W-1:0]  req_arrival_time,
   input  wire logic                            req_final_entry,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [rrjs_pkg::JOB_IDX_W-1:0]  rsp_job_index,
   output logic      [rrjs_pkg::TIME_W-1:0]     rsp_wait_time,
   output logic      [rrjs_pkg::TIME_W-1:0]     rsp_turnaround_time,
   output logic                                 rsp_end_of_schedule
);
   import rrjs_pkg::*;

   localparam int IDX_W = $clog2(MAX_JOBS);
   localparam int CNT_W = $clog2(MAX_JOBS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_JOBS);

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]    job_count_ff, job_count_in;
   logic [CNT_W-1:0]    left_ff, left_in;
   logic [CNT_W-1:0]    issue_cnt_ff, issue_cnt_in;
   logic [TIME_W-1:0]   cur_ff, cur_in;
   logic                first_pass_ff, first_pass_in;
   logic                phase_ff;
   logic                rd_valid_ff;
   logic [IDX_W-1:0]    rd_idx_ff;
   logic [MAX_JOBS-1:0] done_ff, done_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [JOB_IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [TIME_W-1:0]   rsp_wait_ff, rsp_wait_in;
   logic [TIME_W-1:0]   rsp_turn_ff, rsp_turn_in;
   logic                rsp_end_ff, rsp_end_in;

   // handshake and sequencing strobes
   logic load_fire;
   logic full;
   logic issue_fire;
   logic scan_done;
   logic restart;
   logic go_emit;
   logic emit_fire;

   // job RAM and pick unit wiring
   logic [JOB_W-1:0]     wr_data;
   logic [BURST_W-1:0]   wr_burst;
   logic [JOB_W-1:0]     rd_data;
   pick_ctl_type         pick_ctl;
   pick_stat_type        pick_stat;
   logic [IDX_W-1:0]     best_idx;
   logic [TIME_W-1:0]    best_wait;
   logic [BURST_W-1:0]   best_burst;
   logic [ARRIVAL_W-1:0] min_arrival;
   logic [IDX_W+JOB_IDX_W-1:0] best_idx_ext;

   assign full       = job_count_ff == CNT_MAX;
   assign load_fire  = (state_ff == ST_LOAD) && req_valid;
   assign issue_fire = (state_ff == ST_SCAN) && !phase_ff && (issue_cnt_ff < job_count_ff);
   assign scan_done  = (state_ff == ST_SCAN) && (issue_cnt_ff == job_count_ff) &&
                       !rd_valid_ff && !pick_stat.busy;
   // the opening scan only finds the earliest arrival; an empty scan is an idle jump
   assign restart    = scan_done && (first_pass_ff || !pick_stat.best_valid);
   assign go_emit    = scan_done && !restart;
   assign emit_fire  = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // zero burst runs as one tick
   assign wr_burst = (req_burst_time == '0) ? BURST_W'(1) : req_burst_time;
   assign wr_data  = {wr_burst, req_arrival_time};

   // writes happen only in load, reads only in scan, so no forwarding is needed
   rrjs_job_ram #(
      .DEPTH (MAX_JOBS)
   ) u_job_ram (
      .clock   (clock),
      .wr_en   (load_fire && !full),
      .wr_addr (job_count_ff[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (issue_fire),
      .rd_addr (issue_cnt_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign pick_ctl.clear      = (state_ff == ST_LOAD) || restart || emit_fire;
   assign pick_ctl.cand_valid = rd_valid_ff;
   assign pick_ctl.cand_done  = done_ff[rd_idx_ff];

   rrjs_pick_unit #(
      .IDX_W (IDX_W)
   ) u_pick (
      .clock        (clock),
      .reset        (reset),
      .ctl          (pick_ctl),
      .cand_idx     (rd_idx_ff),
      .cand_burst   (rd_data[JOB_W-1:ARRIVAL_W]),
      .cand_arrival (rd_data[ARRIVAL_W-1:0]),
      .cur_time     (cur_ff),
      .stat         (pick_stat),
      .best_idx     (best_idx),
      .best_wait    (best_wait),
      .best_burst   (best_burst),
      .min_arrival  (min_arrival)
   );

   assign best_idx_ext = (IDX_W+JOB_IDX_W)'(best_idx);

   always_comb begin
      state_in      = state_ff;
      job_count_in  = job_count_ff;
      left_in       = left_ff;
      issue_cnt_in  = issue_cnt_ff;
      cur_in        = cur_ff;
      first_pass_in = first_pass_ff;
      done_in       = done_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_idx_in    = rsp_idx_ff;
      rsp_wait_in   = rsp_wait_ff;
      rsp_turn_in   = rsp_turn_ff;
      rsp_end_in    = rsp_end_ff;

      case (state_ff)
         ST_LOAD: begin
            if (load_fire) begin
               // a job beyond the store is dropped, its final mark still counts
               if (!full) begin
                  job_count_in = job_count_ff + CNT_W'(1);
               end
               if (req_final_entry) begin
                  state_in      = ST_SCAN;
                  left_in       = full ? job_count_ff : job_count_ff + CNT_W'(1);
                  issue_cnt_in  = '0;
                  first_pass_in = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (issue_fire) begin
               issue_cnt_in = issue_cnt_ff + CNT_W'(1);
            end
            if (restart) begin
               cur_in        = TIME_W'(min_arrival);
               first_pass_in = 1'b0;
               issue_cnt_in  = '0;
            end
            if (go_emit) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in       = 1'b1;
               rsp_idx_in         = best_idx_ext[JOB_IDX_W-1:0];
               rsp_wait_in        = best_wait;
               rsp_turn_in        = sat_add(best_wait, best_burst);
               rsp_end_in         = left_ff == CNT_W'(1);
               done_in[best_idx]  = 1'b1;
               left_in            = left_ff - CNT_W'(1);
               cur_in             = sat_add(cur_ff, best_burst);
               issue_cnt_in       = '0;
               if (left_ff == CNT_W'(1)) begin
                  // set finished: empty the store, the clock is not cleared
                  state_in     = ST_LOAD;
                  job_count_in = '0;
                  done_in      = '0;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         job_count_ff  <= '0;
         left_ff       <= '0;
         issue_cnt_ff  <= '0;
         cur_ff        <= '0;
         first_pass_ff <= 1'b0;
         phase_ff      <= 1'b0;
         rd_valid_ff   <= 1'b0;
         done_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         job_count_ff  <= job_count_in;
         left_ff       <= left_in;
         issue_cnt_ff  <= issue_cnt_in;
         cur_ff        <= cur_in;
         first_pass_ff <= first_pass_in;
         phase_ff      <= issue_fire;
         rd_valid_ff   <= issue_fire;
         done_ff       <= done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= issue_cnt_ff[IDX_W-1:0];
      rsp_idx_ff  <= rsp_idx_in;
      rsp_wait_ff <= rsp_wait_in;
      rsp_turn_ff <= rsp_turn_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign req_stall           = state_ff != ST_LOAD;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_job_index       = rsp_idx_ff;
   assign rsp_wait_time       = rsp_wait_ff;
   assign rsp_turnaround_time = rsp_turn_ff;
   assign rsp_end_of_schedule = rsp_end_ff;

`ifndef SYNTHESIS
   a_onehot_state : assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_pick_not_done : assert property (@(posedge clock) disable iff (reset)
      emit_fire |-> !done_ff[best_idx])
      else $error("picked a job that already ran");

   a_left_bounded : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (left_ff != '0) && (left_ff <= job_count_ff))
      else $error("remaining job count out of range");

   a_last_pick_ends : assert property (@(posedge clock) disable iff (reset)
      (emit_fire && (left_ff == CNT_W'(1))) |=>
         (state_ff == ST_LOAD) && (job_count_ff == '0) && (done_ff == '0) &&
         rsp_valid_ff && rsp_end_ff)
      else $error("schedule did not close after its last item");

   a_turn_covers_wait : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_turn_ff >= rsp_wait_ff))
      else $error("turnaround below wait");
`endif

endmodule

`default_nettype wire
